// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication.
`define AST_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hdl/rtprs_pkg.sv -----
package rtprs_pkg;

   // Event classes reported with each result.
   localparam logic [2:0] CLS_FIRST      = 3'd0;
   localparam logic [2:0] CLS_SRC_CHANGE = 3'd1;
   localparam logic [2:0] CLS_BACKWARDS  = 3'd2;
   localparam logic [2:0] CLS_REPEAT     = 3'd3;
   localparam logic [2:0] CLS_IN_ORDER   = 3'd4;
   localparam logic [2:0] CLS_GAP        = 3'd5;
   localparam logic [2:0] CLS_TS_RESET   = 3'd6;
   localparam logic [2:0] CLS_SKIP       = 3'd7;

   // Register indexes.
   localparam logic [1:0] REG_QUANTUM       = 2'd0;
   localparam logic [1:0] REG_TICKS_PER_SEC = 2'd1;
   localparam logic [1:0] REG_NS_PER_TICK   = 2'd2;

   localparam logic [15:0] QUANTUM_RESET = 16'd160;
   localparam logic [16:0] TPS_RESET     = 17'd8000;
   localparam logic [29:0] NPT_RESET     = 30'd125000;

   localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
   localparam logic [11:0] CLAMP_SECONDS = 12'd3600;
   localparam logic [31:0] JITTER_ROUND  = 32'd8;
   localparam int          JITTER_SHIFT  = 4;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = 5;

   typedef struct packed {
      logic capture;
      logic div_load;
      logic div_sel_ns;
      logic div_step;
      logic keep_mod;
      logic mul_load;
      logic tsu_load;
      logic diff_load;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic restart;
      logic need_mod;
   } dp_sts_type;

   typedef struct packed {
      logic [2:0]  event_class;
      logic [31:0] highest_seq_ext;
      logic [31:0] expected_count;
      logic [31:0] received_count;
      logic [31:0] jitter_scaled;
      logic [30:0] jitter_peak;
      logic [31:0] arrival_delta;
      logic [31:0] backwards_count;
      logic [31:0] repeat_count;
      logic [31:0] gap_count;
      logic [31:0] ts_reset_count;
      logic [31:0] skip_count;
   } rsp_type;

endpackage

// ----- hdl/rtprs_if.sv -----
interface rtprs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] source_id;
   logic [15:0] seq_number;
   logic [31:0] media_time;
   logic [31:0] arrival_sec;
   logic [29:0] arrival_nsec;
   modport source (output valid, source_id, seq_number, media_time, arrival_sec,
                   arrival_nsec, input ready);
   modport sink (input valid, source_id, seq_number, media_time, arrival_sec,
                 arrival_nsec, output ready);
endinterface

interface rtprs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_class;
   logic [31:0] highest_seq_ext;
   logic [31:0] expected_count;
   logic [31:0] received_count;
   logic [31:0] jitter_scaled;
   logic [30:0] jitter_peak;
   logic [31:0] arrival_delta;
   logic [31:0] backwards_count;
   logic [31:0] repeat_count;
   logic [31:0] gap_count;
   logic [31:0] ts_reset_count;
   logic [31:0] skip_count;
   modport source (output valid, event_class, highest_seq_ext, expected_count,
                   received_count, jitter_scaled, jitter_peak, arrival_delta,
                   backwards_count, repeat_count, gap_count, ts_reset_count,
                   skip_count, input ready);
   modport sink (input valid, event_class, highest_seq_ext, expected_count,
                 received_count, jitter_scaled, jitter_peak, arrival_delta,
                 backwards_count, repeat_count, gap_count, ts_reset_count,
                 skip_count, output ready);
endinterface

interface rtprs_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [29:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

// ----- hdl/rtprs_ctrl.sv -----
module rtprs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rtprs_pkg::dp_sts_type  sts,
   output rtprs_pkg::dp_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_PREP    = 4'd1;
   localparam logic [3:0] S_MOD     = 4'd2;
   localparam logic [3:0] S_MODEND  = 4'd3;
   localparam logic [3:0] S_NS      = 4'd4;
   localparam logic [3:0] S_MUL     = 4'd5;
   localparam logic [3:0] S_TSU     = 4'd6;
   localparam logic [3:0] S_DIFF    = 4'd7;
   localparam logic [3:0] S_COMMIT  = 4'd8;

   localparam logic [rtprs_pkg::DIV_CNT_W-1:0] CNT_LAST =
      rtprs_pkg::DIV_CNT_W'(rtprs_pkg::DIV_STEPS - 1);

   logic [3:0]                      state_ff, state_in;
   logic [rtprs_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_PREP;
            end
         end
         S_PREP: begin
            cnt_in = '0;
            if (sts.restart) begin
               state_in = S_COMMIT;
            end else if (sts.need_mod) begin
               cmd.div_load = 1'b1;
               state_in     = S_MOD;
            end else begin
               cmd.div_load   = 1'b1;
               cmd.div_sel_ns = 1'b1;
               state_in       = S_NS;
            end
         end
         S_MOD: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_MODEND;
            end
         end
         S_MODEND: begin
            cmd.keep_mod   = 1'b1;
            cmd.div_load   = 1'b1;
            cmd.div_sel_ns = 1'b1;
            cnt_in         = '0;
            state_in       = S_NS;
         end
         S_NS: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = S_TSU;
         end
         S_TSU: begin
            cmd.tsu_load = 1'b1;
            state_in     = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff_load = 1'b1;
            state_in      = S_COMMIT;
         end
         S_COMMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/rtprs_datapath.sv -----
module rtprs_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [1:0]            csr_addr,
   input  logic [29:0]           csr_data,
   input  logic [31:0]           req_source_id,
   input  logic [15:0]           req_seq_number,
   input  logic [31:0]           req_media_time,
   input  logic [31:0]           req_arrival_sec,
   input  logic [29:0]           req_arrival_nsec,
   input  rtprs_pkg::dp_cmd_type cmd,
   output rtprs_pkg::dp_sts_type sts,
   output rtprs_pkg::rsp_type    rsp
);

   // Configuration.
   logic [15:0] quantum_ff;
   logic [16:0] tps_ff;
   logic [29:0] npt_ff;

   // Captured packet.
   logic [31:0] src_ff;
   logic [15:0] seq_ff;
   logic [31:0] time_ff;
   logic [31:0] sec_ff;
   logic [29:0] nsec_ff;

   // Per-source state.
   logic        seen_ff,   seen_in;
   logic [31:0] cur_src_ff, cur_src_in;
   logic [15:0] base_ff,   base_in;
   logic [31:0] max_ext_ff, max_ext_in;
   logic [31:0] expect_ff, expect_in;
   logic [31:0] recv_ff,   recv_in;
   logic [31:0] jit_ff,    jit_in;
   logic [30:0] peak_ff,   peak_in;
   logic [15:0] prev_seq_ff;
   logic [31:0] prev_time_ff;
   logic [31:0] prev_sec_ff;
   logic [29:0] prev_nsec_ff;
   logic [31:0] delta_ff,  delta_in;
   logic [31:0] cls_cnt_ff [5];
   logic [4:0]  cls_inc;

   // Divider and arithmetic pipeline.
   logic [29:0] rem_ff;
   logic [31:0] quo_ff;
   logic [29:0] dsr_ff;
   logic        mod_zero_ff;
   logic [31:0] prod_ff;
   logic [28:0] clampv_ff;
   logic [31:0] tsu_ff;
   logic [31:0] tsdc_ff;
   logic [31:0] mag_ff;

   logic [15:0] q_eff;
   logic [29:0] npt_eff;
   logic [15:0] step;
   logic [31:0] tsd;
   logic        tsd_pos;
   logic        restart;
   logic [32:0] sd_raw;
   logic [33:0] sd_b;
   logic [30:0] nd_raw;
   logic [30:0] nd_adj;
   logic [30:0] nd_use;
   logic [30:0] nd_mag_w;
   logic        borrow;
   logic        clamp;
   logic [31:0] sd_use;
   logic [30:0] rem_shift;
   logic        div_ge;
   logic [30:0] rem_sub;
   logic [48:0] prod_full;
   logic [28:0] clampv_full;
   logic [31:0] quo_s;
   logic [31:0] clampv32;
   logic [31:0] clampv_neg;
   logic [31:0] diff;
   logic [15:0] step2;
   logic [15:0] ext_hi;
   logic [31:0] jit_round;
   logic [30:0] mag_sat;
   logic [2:0]  cls;

   assign q_eff   = (quantum_ff == '0) ? 16'd1 : quantum_ff;
   assign npt_eff = (npt_ff == '0) ? 30'd1 : npt_ff;

   // Packet classification inputs.
   assign step    = seq_ff - prev_seq_ff;
   assign tsd     = time_ff - prev_time_ff;
   assign tsd_pos = !tsd[31] && (tsd != '0);
   assign restart = !seen_ff || (src_ff != cur_src_ff);

   assign sts.restart  = restart;
   assign sts.need_mod = !restart && (step == 16'd1) && (tsd != {16'b0, quantum_ff})
                         && tsd_pos;

   // Arrival interval split into whole seconds and nanoseconds.
   assign sd_raw   = {1'b0, sec_ff} - {1'b0, prev_sec_ff};
   assign nd_raw   = {1'b0, nsec_ff} - {1'b0, prev_nsec_ff};
   assign borrow   = nd_raw[30];
   assign sd_b     = {sd_raw[32], sd_raw} - {33'b0, borrow};
   assign clamp    = $signed(sd_b) >= $signed({22'b0, rtprs_pkg::CLAMP_SECONDS});
   assign sd_use   = clamp ? {20'b0, rtprs_pkg::CLAMP_SECONDS} : sd_b[31:0];
   assign nd_adj   = borrow ? (nd_raw + {1'b0, rtprs_pkg::NS_PER_SEC}) : nd_raw;
   assign nd_use   = clamp ? '0 : nd_adj;
   assign nd_mag_w = nd_use[30] ? (~nd_use + 31'd1) : nd_use;

   // One restoring divide step per cycle.
   assign rem_shift = {rem_ff, quo_ff[31]};
   assign div_ge    = rem_shift >= {1'b0, dsr_ff};
   assign rem_sub   = rem_shift - {1'b0, dsr_ff};

   assign prod_full   = sd_use * tps_ff;
   assign clampv_full = tps_ff * rtprs_pkg::CLAMP_SECONDS;

   assign quo_s      = nd_use[30] ? (32'd0 - {2'b0, quo_ff[29:0]}) : {2'b0, quo_ff[29:0]};
   assign clampv32   = {3'b0, clampv_ff};
   assign clampv_neg = 32'd0 - clampv32;
   assign diff       = tsu_ff - tsdc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= rtprs_pkg::QUANTUM_RESET;
         tps_ff     <= rtprs_pkg::TPS_RESET;
         npt_ff     <= rtprs_pkg::NPT_RESET;
      end else if (csr_write) begin
         unique case (csr_addr)
            rtprs_pkg::REG_QUANTUM:       quantum_ff <= csr_data[15:0];
            rtprs_pkg::REG_TICKS_PER_SEC: tps_ff     <= csr_data[16:0];
            rtprs_pkg::REG_NS_PER_TICK:   npt_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         src_ff  <= req_source_id;
         seq_ff  <= req_seq_number;
         time_ff <= req_media_time;
         sec_ff  <= req_arrival_sec;
         nsec_ff <= req_arrival_nsec;
      end
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= cmd.div_sel_ns ? {2'b0, nd_mag_w[29:0]} : tsd;
         dsr_ff <= cmd.div_sel_ns ? npt_eff : {14'b0, q_eff};
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? rem_sub[29:0] : rem_shift[29:0];
         quo_ff <= {quo_ff[30:0], div_ge};
      end
      if (cmd.keep_mod) begin
         mod_zero_ff <= (rem_ff == '0);
      end
      if (cmd.mul_load) begin
         prod_ff   <= prod_full[31:0];
         clampv_ff <= clampv_full;
      end
      if (cmd.tsu_load) begin
         tsu_ff <= prod_ff + quo_s;
         if ($signed(tsd) > $signed(clampv32)) begin
            tsdc_ff <= clampv32;
         end else if ($signed(tsd) < $signed(clampv_neg)) begin
            tsdc_ff <= clampv_neg;
         end else begin
            tsdc_ff <= tsd;
         end
      end
      if (cmd.diff_load) begin
         mag_ff <= diff[31] ? (32'd0 - diff) : diff;
      end
   end

   // Statistics update at commit.
   always_comb begin
      seen_in    = seen_ff;
      cur_src_in = cur_src_ff;
      base_in    = base_ff;
      max_ext_in = max_ext_ff;
      expect_in  = expect_ff;
      recv_in    = recv_ff;
      jit_in     = jit_ff;
      peak_in    = peak_ff;
      delta_in   = delta_ff;
      cls_inc    = '0;
      step2      = seq_ff - max_ext_ff[15:0];
      ext_hi     = max_ext_ff[31:16] + {15'b0, (seq_ff < max_ext_ff[15:0])};
      jit_round  = (jit_ff + rtprs_pkg::JITTER_ROUND) >> rtprs_pkg::JITTER_SHIFT;
      mag_sat    = mag_ff[31] ? 31'h7FFFFFFF : mag_ff[30:0];
      if (restart) begin
         cls = seen_ff ? rtprs_pkg::CLS_SRC_CHANGE : rtprs_pkg::CLS_FIRST;
      end else if (step[15]) begin
         cls = rtprs_pkg::CLS_BACKWARDS;
      end else if (step == '0) begin
         cls = rtprs_pkg::CLS_REPEAT;
      end else if (step == 16'd1) begin
         if (tsd == {16'b0, quantum_ff}) begin
            cls = rtprs_pkg::CLS_IN_ORDER;
         end else if (tsd_pos && mod_zero_ff) begin
            cls = rtprs_pkg::CLS_GAP;
         end else begin
            cls = rtprs_pkg::CLS_TS_RESET;
         end
      end else begin
         cls = rtprs_pkg::CLS_SKIP;
      end
      if (restart) begin
         seen_in    = 1'b1;
         cur_src_in = src_ff;
         base_in    = seq_ff;
         max_ext_in = {16'b0, seq_ff};
         expect_in  = 32'd1;
         recv_in    = 32'd1;
         jit_in     = '0;
      end else begin
         case (cls)
            rtprs_pkg::CLS_BACKWARDS: cls_inc = 5'b00001;
            rtprs_pkg::CLS_REPEAT:    cls_inc = 5'b00010;
            rtprs_pkg::CLS_GAP:       cls_inc = 5'b00100;
            rtprs_pkg::CLS_TS_RESET:  cls_inc = 5'b01000;
            rtprs_pkg::CLS_SKIP:      cls_inc = 5'b10000;
            default:                  cls_inc = 5'b00000;
         endcase
         recv_in = recv_ff + 32'd1;
         if ((step2 != '0) && !step2[15]) begin
            max_ext_in = {ext_hi, seq_ff};
            expect_in  = {ext_hi, seq_ff} - {16'b0, base_ff} + 32'd1;
         end
         delta_in = tsu_ff;
         jit_in   = jit_ff + mag_ff - jit_round;
         if (mag_sat > peak_ff) begin
            peak_in = mag_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         cur_src_ff   <= '0;
         base_ff      <= '0;
         max_ext_ff   <= '0;
         expect_ff    <= '0;
         recv_ff      <= '0;
         jit_ff       <= '0;
         peak_ff      <= '0;
         prev_seq_ff  <= '0;
         prev_time_ff <= '0;
         prev_sec_ff  <= '0;
         prev_nsec_ff <= '0;
         delta_ff     <= '0;
         for (int i = 0; i < 5; i++) begin
            cls_cnt_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         seen_ff      <= seen_in;
         cur_src_ff   <= cur_src_in;
         base_ff      <= base_in;
         max_ext_ff   <= max_ext_in;
         expect_ff    <= expect_in;
         recv_ff      <= recv_in;
         jit_ff       <= jit_in;
         peak_ff      <= peak_in;
         prev_seq_ff  <= seq_ff;
         prev_time_ff <= time_ff;
         prev_sec_ff  <= sec_ff;
         prev_nsec_ff <= nsec_ff;
         delta_ff     <= delta_in;
         for (int i = 0; i < 5; i++) begin
            if (cls_inc[i]) begin
               cls_cnt_ff[i] <= cls_cnt_ff[i] + 32'd1;
            end
         end
      end
   end

   // Result register, loaded with the updated statistics.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp.event_class     <= cls;
         rsp.highest_seq_ext <= max_ext_in;
         rsp.expected_count  <= expect_in;
         rsp.received_count  <= recv_in;
         rsp.jitter_scaled   <= jit_in;
         rsp.jitter_peak     <= peak_in;
         rsp.arrival_delta   <= delta_in;
         rsp.backwards_count <= cls_cnt_ff[0] + {31'b0, cls_inc[0]};
         rsp.repeat_count    <= cls_cnt_ff[1] + {31'b0, cls_inc[1]};
         rsp.gap_count       <= cls_cnt_ff[2] + {31'b0, cls_inc[2]};
         rsp.ts_reset_count  <= cls_cnt_ff[3] + {31'b0, cls_inc[3]};
         rsp.skip_count      <= cls_cnt_ff[4] + {31'b0, cls_inc[4]};
      end
   end

endmodule

// ----- hdl/rtp_receive_statistics.sv -----
// RTP receiver statistics, one received packet header per beat.
// The req_chan channel carries one header per beat: SSRC, sequence number,
// RTP timestamp and arrival time. Each header yields exactly one beat on
// rsp_chan with the event class and the updated per-source statistics.
// The csr_chan channel writes the quantum, clock rate and ns-per-tick
// registers; it is always ready and should only be used while idle.
// A header that starts or restarts the statistics (first packet or a new
// SSRC) skips the divider and goes from preparation straight to commit.
// Any other header runs the shared one-bit-per-cycle divider for the
// nanosecond part and, for in-order packets with an irregular positive
// timestamp step, first a pass for the quantum modulo. In both cases the
// result is valid in the same cycle in which the next header can be taken.
// Only one header is in flight; the next is accepted once the result is in
// the output register, even if the receiver has not taken it yet.
// A stalled receiver holds the result; the block waits at commit for it.
// Reset clears all statistics, restores the register defaults and leaves
// no result pending.
`include "assert_macros.svh"

module rtp_receive_statistics (
   input  logic              clock,
   input  logic              reset,
   rtprs_req_if.sink         req_chan,
   rtprs_rsp_if.source       rsp_chan,
   rtprs_csr_if.sink         csr_chan
);

   rtprs_pkg::dp_cmd_type cmd;
   rtprs_pkg::dp_sts_type sts;
   rtprs_pkg::rsp_type    rsp;

   // Configuration writes never stall.
   assign csr_chan.ready = 1'b1;

   rtprs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rtprs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_chan.valid),
      .csr_addr         (csr_chan.addr),
      .csr_data         (csr_chan.data),
      .req_source_id    (req_chan.source_id),
      .req_seq_number   (req_chan.seq_number),
      .req_media_time   (req_chan.media_time),
      .req_arrival_sec  (req_chan.arrival_sec),
      .req_arrival_nsec (req_chan.arrival_nsec),
      .cmd              (cmd),
      .sts              (sts),
      .rsp              (rsp)
   );

   assign rsp_chan.event_class     = rsp.event_class;
   assign rsp_chan.highest_seq_ext = rsp.highest_seq_ext;
   assign rsp_chan.expected_count  = rsp.expected_count;
   assign rsp_chan.received_count  = rsp.received_count;
   assign rsp_chan.jitter_scaled   = rsp.jitter_scaled;
   assign rsp_chan.jitter_peak     = rsp.jitter_peak;
   assign rsp_chan.arrival_delta   = rsp.arrival_delta;
   assign rsp_chan.backwards_count = rsp.backwards_count;
   assign rsp_chan.repeat_count    = rsp.repeat_count;
   assign rsp_chan.gap_count       = rsp.gap_count;
   assign rsp_chan.ts_reset_count  = rsp.ts_reset_count;
   assign rsp_chan.skip_count      = rsp.skip_count;

   // One header at a time: after a beat is taken the input closes.
   `AST_NEXT(a_one_in_flight, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)

   // A restart always reports a fresh count of one in the first wrap cycle.
   `AST_IMP(a_restart_counts, clock, reset, rsp_chan.valid && (rsp_chan.event_class == rtprs_pkg::CLS_FIRST || rsp_chan.event_class == rtprs_pkg::CLS_SRC_CHANGE), rsp_chan.received_count == 32'd1 && rsp_chan.expected_count == 32'd1 && rsp_chan.highest_seq_ext[31:16] == 16'd0)

endmodule
